// ===== rtl/lss_pkg.sv =====
package lss_pkg;

   localparam int DEPTH_DEFAULT = 64;
   localparam int DATA_W        = 32;
   localparam int OP_W          = 3;
   localparam int STATUS_W      = 2;
   localparam int ENTRY_COUNT_W = 7;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH       = 3'd0,
      OP_POP        = 3'd1,
      OP_PEEK       = 3'd2,
      OP_FETCH      = 3'd3,
      OP_UPDATE     = 3'd4,
      OP_CLEAR      = 3'd5,
      OP_INS_BOTTOM = 3'd6,
      OP_DEL_BOTTOM = 3'd7
   } lss_op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EMPTY     = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_FULL      = 2'd3
   } lss_status_type;

endpackage

// ===== rtl/lss_ram.sv =====
module lss_ram import lss_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [AW-1:0]     rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/lifo_stack_with_search.sv =====
// lifo_stack_with_search: bounded lifo of signed 32-bit words with search
//
// request channel (req_valid/req_ready): req_type selects push, pop, peek,
// fetch, update, clear, insert at bottom or delete at bottom; req_data_value
// is the word to store or to look for, req_new_value the replacement word.
// result channel (rsp_valid/rsp_ready): exactly one result per request with
// status, found flag, top word (zero when empty), entry count and empty flag.
//
// a request is registered, then executed once the output register is free; a
// pop that leaves entries reads the new top back from memory first, and fetch
// and update read one entry per cycle from the top down through the single
// read port. a new request is taken only once the previous result is in the
// output register; the words live in one single-port-read memory and the top
// word is cached in a register.
// reset clears the count and the top pointer; the memory is not cleared.
// when the receiver stalls the result stays in the output register; the next
// request is still taken and then holds before it touches the stack.
module lifo_stack_with_search import lss_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [OP_W-1:0]                 req_type,
   input  logic signed [DATA_W-1:0]        req_data_value,
   input  logic signed [DATA_W-1:0]        req_new_value,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [STATUS_W-1:0]             rsp_status,
   output logic                            rsp_found,
   output logic signed [DATA_W-1:0]        rsp_top_value,
   output logic [ENTRY_COUNT_W-1:0]        rsp_entry_count,
   output logic                            rsp_is_empty
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_POP_WAIT,
      ST_SCAN
   } state_type;

   // control state
   state_type state_ff, state_in;
   logic              rsp_valid_ff;
   logic [CW-1:0]     count_ff, count_in;
   logic [AW-1:0]     top_ff, top_in;
   logic              chk_valid_ff, chk_valid_in;

   // payload
   lss_op_type        op_ff;
   logic [DATA_W-1:0] op_data_ff;
   logic [DATA_W-1:0] op_new_ff;
   logic [DATA_W-1:0] top_val_ff, top_val_in;
   logic [AW-1:0]     scan_ptr_ff, scan_ptr_in;
   logic [CW-1:0]     scan_left_ff, scan_left_in;
   logic [AW-1:0]     chk_addr_ff, chk_addr_in;

   logic [STATUS_W-1:0]      rsp_status_ff;
   logic                     rsp_found_ff;
   logic [DATA_W-1:0]        rsp_top_value_ff;
   logic [ENTRY_COUNT_W-1:0] rsp_entry_count_ff;
   logic                     rsp_is_empty_ff;

   // memory port
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [DATA_W-1:0] wr_data;
   logic [AW-1:0]     rd_addr;
   logic [DATA_W-1:0] rd_data;

   // combinational helpers
   logic              full;
   logic              empty;
   logic              out_free;
   logic              match;
   logic              emit;
   lss_status_type    status;
   logic              found;
   logic [AW-1:0]     top_inc;
   logic [AW-1:0]     top_dec;
   logic [AW-1:0]     scan_dec;
   logic [CW:0]       top_wide;
   logic [CW:0]       count_wide;
   logic [AW-1:0]     bottom_slot;

   lss_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign match    = chk_valid_ff && (rd_data == op_data_ff);

   // ring pointer steps with wrap at DEPTH
   assign top_inc  = (top_ff == AW'(DEPTH - 1)) ? '0 : top_ff + 1'b1;
   assign top_dec  = (top_ff == '0) ? AW'(DEPTH - 1) : top_ff - 1'b1;
   assign scan_dec = (scan_ptr_ff == '0) ? AW'(DEPTH - 1) : scan_ptr_ff - 1'b1;

   // free slot just under the bottom entry: top - count, wrapped
   assign top_wide    = (CW + 1)'(top_ff);
   assign count_wide  = (CW + 1)'(count_ff);
   assign bottom_slot = (top_wide >= count_wide)
                      ? AW'(top_wide - count_wide)
                      : AW'(top_wide + (CW + 1)'(DEPTH) - count_wide);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      top_in       = top_ff;
      top_val_in   = top_val_ff;
      scan_ptr_in  = scan_ptr_ff;
      scan_left_in = scan_left_ff;
      chk_valid_in = 1'b0;
      chk_addr_in  = chk_addr_ff;
      emit         = 1'b0;
      status       = STATUS_OK;
      found        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = top_ff;
      wr_data      = op_data_ff;
      rd_addr      = top_dec;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end

         // stack is touched only once the output register can take the result
         ST_EXEC: begin
            if (out_free) begin
               unique case (op_ff)
                  OP_PUSH: begin
                     if (full) begin
                        status = STATUS_FULL;
                     end else begin
                        wr_en      = 1'b1;
                        wr_addr    = empty ? top_ff : top_inc;
                        top_in     = wr_addr;
                        top_val_in = op_data_ff;
                        count_in   = count_ff + 1'b1;
                     end
                     emit = 1'b1;
                  end
                  OP_POP: begin
                     if (empty) begin
                        status = STATUS_EMPTY;
                        emit   = 1'b1;
                     end else begin
                        count_in = count_ff - 1'b1;
                        if (count_ff == CW'(1)) begin
                           emit = 1'b1;
                        end else begin
                           // new top comes back from memory next cycle
                           top_in   = top_dec;
                           state_in = ST_POP_WAIT;
                        end
                     end
                  end
                  OP_PEEK: begin
                     if (empty) begin
                        status = STATUS_EMPTY;
                     end
                     emit = 1'b1;
                  end
                  OP_FETCH, OP_UPDATE: begin
                     if (empty) begin
                        status = STATUS_EMPTY;
                        emit   = 1'b1;
                     end else begin
                        scan_ptr_in  = top_ff;
                        scan_left_in = count_ff;
                        state_in     = ST_SCAN;
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                     emit     = 1'b1;
                  end
                  OP_INS_BOTTOM: begin
                     if (full) begin
                        status = STATUS_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = empty ? top_ff : bottom_slot;
                        if (empty) begin
                           top_val_in = op_data_ff;
                        end
                        count_in = count_ff + 1'b1;
                     end
                     emit = 1'b1;
                  end
                  OP_DEL_BOTTOM: begin
                     if (empty) begin
                        status = STATUS_EMPTY;
                     end else begin
                        count_in = count_ff - 1'b1;
                     end
                     emit = 1'b1;
                  end
                  default: begin
                     emit = 1'b1;
                  end
               endcase
            end
         end

         ST_POP_WAIT: begin
            top_val_in = rd_data;
            emit       = 1'b1;
         end

         // one read issued and one compare done per cycle, top down
         ST_SCAN: begin
            rd_addr = scan_ptr_ff;
            if (match) begin
               found = 1'b1;
               emit  = 1'b1;
               if (op_ff == OP_UPDATE) begin
                  wr_en   = 1'b1;
                  wr_addr = chk_addr_ff;
                  wr_data = op_new_ff;
                  if (chk_addr_ff == top_ff) begin
                     top_val_in = op_new_ff;
                  end
               end
            end else if (scan_left_ff != '0) begin
               chk_valid_in = 1'b1;
               chk_addr_in  = scan_ptr_ff;
               scan_ptr_in  = scan_dec;
               scan_left_in = scan_left_ff - 1'b1;
            end else begin
               status = STATUS_NOT_FOUND;
               emit   = 1'b1;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (emit) begin
         state_in = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         top_ff       <= '0;
         chk_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         top_ff       <= top_in;
         chk_valid_ff <= chk_valid_in;
         top_val_ff   <= top_val_in;
         scan_ptr_ff  <= scan_ptr_in;
         scan_left_ff <= scan_left_in;
         chk_addr_ff  <= chk_addr_in;

         // capture the request on transfer
         if (req_valid && req_ready) begin
            op_ff      <= lss_op_type'(req_type);
            op_data_ff <= req_data_value;
            op_new_ff  <= req_new_value;
         end

         // output register
         if (emit) begin
            rsp_valid_ff       <= 1'b1;
            rsp_status_ff      <= status;
            rsp_found_ff       <= found;
            rsp_top_value_ff   <= (count_in == '0) ? '0 : top_val_in;
            rsp_entry_count_ff <= ENTRY_COUNT_W'(count_in);
            rsp_is_empty_ff    <= (count_in == '0);
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_top_value   = rsp_top_value_ff;
   assign rsp_entry_count = rsp_entry_count_ff;
   assign rsp_is_empty    = rsp_is_empty_ff;

   // count never passes the ring size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count beyond depth");

   // one request at a time: a transfer closes the request side
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while busy");

   // an empty stack reports a zero top word
   a_empty_top_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_empty) |-> (rsp_top_value == '0))
      else $error("nonzero top on empty stack");

   // a match always comes with an ok status
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |-> (rsp_status == STATUS_OK))
      else $error("found flag with error status");

endmodule

// ===== dv/lifo_stack_with_search_test.sv =====
`timescale 1ns / 1ps

import lss_pkg::*;

typedef struct packed {
   lss_status_type                 status;
   logic                           found;
   logic [DATA_W-1:0]              top_value;
   logic [ENTRY_COUNT_W-1:0]       entry_count;
   logic                           is_empty;
} stack_result_type;

class lifo_shadow_type;
   localparam int SLOTS = DEPTH_DEFAULT;

   logic [DATA_W-1:0]        words [SLOTS];
   logic [5:0]               top_pos;
   logic [ENTRY_COUNT_W-1:0] held;
   stack_result_type         awaited_results [$];
   int                       failures;
   int                       op_seen [8];
   int                       full_hits;
   int                       empty_hits;

   function new();
      top_pos    = '0;
      held       = '0;
      failures   = 0;
      full_hits  = 0;
      empty_hits = 0;
      foreach (op_seen[i]) op_seen[i] = 0;
      foreach (words[i]) words[i] = '0;
   endfunction

   // compute the result of one accepted request and queue it
   function void note_request(lss_op_type op, logic [DATA_W-1:0] dv,
                              logic [DATA_W-1:0] nv);
      stack_result_type res;
      logic [5:0]       pos;
      logic             hit;
      logic [5:0]       hit_pos;
      logic             is_full;

      res     = '0;
      hit     = 1'b0;
      hit_pos = '0;
      is_full = (held >= SLOTS);
      res.status = STATUS_OK;
      op_seen[op]++;
      if (is_full && (op == OP_PUSH || op == OP_INS_BOTTOM)) full_hits++;
      if (held == 0 && op != OP_PUSH && op != OP_INS_BOTTOM && op != OP_CLEAR)
         empty_hits++;

      case (op)
         OP_PUSH: begin
            if (is_full) begin
               res.status = STATUS_FULL;
            end else begin
               if (held != 0) top_pos = top_pos + 6'd1;
               words[top_pos] = dv;
               held = held + 7'd1;
            end
         end
         OP_POP: begin
            if (held == 0) begin
               res.status = STATUS_EMPTY;
            end else begin
               held = held - 7'd1;
               if (held != 0) top_pos = top_pos - 6'd1;
            end
         end
         OP_PEEK: begin
            if (held == 0) res.status = STATUS_EMPTY;
         end
         OP_FETCH, OP_UPDATE: begin
            if (held == 0) begin
               res.status = STATUS_EMPTY;
            end else begin
               // scan from the top down, first match wins
               for (int k = 0; k < held; k++) begin
                  pos = top_pos - 6'(k);
                  if (!hit && words[pos] == dv) begin
                     hit     = 1'b1;
                     hit_pos = pos;
                  end
               end
               if (!hit) begin
                  res.status = STATUS_NOT_FOUND;
               end else begin
                  res.found = 1'b1;
                  if (op == OP_UPDATE) words[hit_pos] = nv;
               end
            end
         end
         OP_CLEAR: begin
            held = '0;
         end
         OP_INS_BOTTOM: begin
            if (is_full) begin
               res.status = STATUS_FULL;
            end else if (held == 0) begin
               words[top_pos] = dv;
               held = 7'd1;
            end else begin
               words[top_pos - 6'(held)] = dv;
               held = held + 7'd1;
            end
         end
         default: begin
            if (held == 0) res.status = STATUS_EMPTY;
            else held = held - 7'd1;
         end
      endcase

      res.top_value   = (held != 0) ? words[top_pos] : '0;
      res.entry_count = held;
      res.is_empty    = (held == 0);
      awaited_results.push_back(res);
   endfunction

   function void compare_field(string name, logic [DATA_W-1:0] want,
                               logic [DATA_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         failures++;
      end
   endfunction

   function void check_result(logic [STATUS_W-1:0] status, logic found,
                              logic [DATA_W-1:0] top_value,
                              logic [ENTRY_COUNT_W-1:0] entry_count,
                              logic is_empty);
      stack_result_type want;

      if (awaited_results.size() == 0) begin
         $error("result transfer with no request outstanding");
         failures++;
         return;
      end
      want = awaited_results.pop_front();
      compare_field("status", 32'(want.status), 32'(status));
      compare_field("found", 32'(want.found), 32'(found));
      compare_field("top_value", want.top_value, top_value);
      compare_field("entry_count", 32'(want.entry_count), 32'(entry_count));
      compare_field("is_empty", 32'(want.is_empty), 32'(is_empty));
   endfunction
endclass

module lifo_stack_with_search_test;

   localparam int RANDOM_ITEMS = 550;
   localparam int QUIET_FROM   = 470;    // no idling on either side past this item
   localparam int PHASE_LEN    = 90;
   localparam int STALL_LIMIT  = 1000;   // cycles without any transfer

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_ready;
   logic [OP_W-1:0]                req_type;
   logic signed [DATA_W-1:0]       req_data_value;
   logic signed [DATA_W-1:0]       req_new_value;
   logic                           rsp_valid;
   logic                           rsp_ready;
   logic [STATUS_W-1:0]            rsp_status;
   logic                           rsp_found;
   logic signed [DATA_W-1:0]       rsp_top_value;
   logic [ENTRY_COUNT_W-1:0]       rsp_entry_count;
   logic                           rsp_is_empty;

   lifo_shadow_type shadow;
   logic        quiet;          // set for the last stretch: no idling at all
   int          rsp_stall_left;
   int          idle_cycles;

   // small pool of words so that searches and updates actually hit
   logic [DATA_W-1:0] word_pool [8] = '{
      32'h0000_0000, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff,
      32'h0000_0001, 32'h5555_5555, 32'haaaa_aaaa, 32'h0000_002a
   };

   lifo_stack_with_search i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_data_value  (req_data_value),
      .req_new_value   (req_new_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_found       (rsp_found),
      .rsp_top_value   (rsp_top_value),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty)
   );

   // 10 ns clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // receiver: random stall bursts, driven on the falling edge
   always @(negedge clock) begin
      if (rsp_stall_left != 0) begin
         rsp_stall_left <= rsp_stall_left - 1;
         rsp_ready      <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         rsp_stall_left <= $urandom_range(0, 18);
         rsp_ready      <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // result monitor: compare every result transfer with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         shadow.check_result(rsp_status, rsp_found, rsp_top_value,
                             rsp_entry_count, rsp_is_empty);
   end

   // count cycles in which neither channel moves a transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   // watchdog
   initial begin
      wait (idle_cycles >= STALL_LIMIT);
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
   end

   // present one request at a falling edge and hold it until the transfer;
   // returns at the next falling edge
   task automatic send_request(input lss_op_type op, input logic [DATA_W-1:0] dv,
                               input logic [DATA_W-1:0] nv);
      req_valid      <= 1'b1;
      req_type       <= op;
      req_data_value <= dv;
      req_new_value  <= nv;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      shadow.note_request(op, dv, nv);
      @(negedge clock);
   endtask

   function automatic logic [DATA_W-1:0] pick_word();
      if ($urandom_range(0, 9) < 6) return word_pool[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   // operation mix per phase: fill toward full, drain toward empty, or uniform
   function automatic lss_op_type pick_op(int mode);
      int r;
      r = $urandom_range(0, 99);
      case (mode)
         0: begin
            if (r < 60)      return OP_PUSH;
            else if (r < 80) return OP_INS_BOTTOM;
            else if (r < 83) return OP_POP;
            else if (r < 85) return OP_DEL_BOTTOM;
            else if (r < 89) return OP_PEEK;
            else if (r < 94) return OP_FETCH;
            else             return OP_UPDATE;
         end
         1: begin
            if (r < 40)      return OP_POP;
            else if (r < 65) return OP_DEL_BOTTOM;
            else if (r < 72) return OP_PUSH;
            else if (r < 77) return OP_INS_BOTTOM;
            else if (r < 82) return OP_PEEK;
            else if (r < 89) return OP_FETCH;
            else if (r < 96) return OP_UPDATE;
            else             return OP_CLEAR;
         end
         default: return lss_op_type'($urandom_range(0, 7));
      endcase
   endfunction

   initial begin
      int mode;

      shadow         = new();
      quiet          = 1'b0;
      rsp_stall_left = 0;
      idle_cycles    = 0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_type       = OP_PUSH;
      req_data_value = '0;
      req_new_value  = '0;
      rsp_ready      = 1'b0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: peek, pop, fetch, update, delete at bottom and clear on an empty stack first
      send_request(OP_PEEK,       32'h0000_0000, 32'h0000_0000);
      send_request(OP_POP,        32'h0000_0000, 32'h0000_0000);
      send_request(OP_FETCH,      32'h7fff_ffff, 32'h0000_0000);
      send_request(OP_UPDATE,     32'h8000_0000, 32'hffff_ffff);
      send_request(OP_DEL_BOTTOM, 32'h0000_0000, 32'h0000_0000);
      send_request(OP_CLEAR,      32'h0000_0000, 32'h0000_0000);
      // extreme words
      send_request(OP_PUSH,       32'h7fff_ffff, 32'h0000_0000);
      send_request(OP_PUSH,       32'h8000_0000, 32'h0000_0000);
      send_request(OP_PUSH,       32'h0000_0000, 32'h0000_0000);
      send_request(OP_PUSH,       32'hffff_ffff, 32'h0000_0000);
      send_request(OP_PEEK,       32'h0000_0000, 32'h0000_0000);
      // search hit at the bottom, then a miss
      send_request(OP_FETCH,      32'h7fff_ffff, 32'h0000_0000);
      send_request(OP_FETCH,      32'h1234_5678, 32'h0000_0000);
      // update of the top word, then two equal words: only the upper one changes
      send_request(OP_UPDATE,     32'hffff_ffff, 32'h8000_0000);
      send_request(OP_UPDATE,     32'h8000_0000, 32'h7fff_ffff);
      send_request(OP_UPDATE,     32'h1357_9bdf, 32'hffff_ffff);
      // bottom end of the ring
      send_request(OP_INS_BOTTOM, 32'h5555_5555, 32'h0000_0000);
      send_request(OP_DEL_BOTTOM, 32'h0000_0000, 32'h0000_0000);
      send_request(OP_POP,        32'h0000_0000, 32'h0000_0000);
      send_request(OP_POP,        32'h0000_0000, 32'h0000_0000);
      // clear keeps stored words, then insert at bottom on an empty stack
      send_request(OP_CLEAR,      32'h0000_0000, 32'h0000_0000);
      send_request(OP_INS_BOTTOM, 32'haaaa_aaaa, 32'h0000_0000);
      send_request(OP_PUSH,       32'h0000_0007, 32'h0000_0000);
      send_request(OP_POP,        32'h0000_0000, 32'h0000_0000);
      send_request(OP_POP,        32'h0000_0000, 32'h0000_0000);

      // random part in phases; fill phases run the stack into full
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         mode = (i / PHASE_LEN) % 3;
         if (i == QUIET_FROM) quiet = 1'b1;
         if (i == 2 * PHASE_LEN) begin
            // hold off until the block has returned everything
            req_valid <= 1'b0;
            while (shadow.awaited_results.size() != 0) @(negedge clock);
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clock);
         end
         send_request(pick_op(mode), pick_word(),
                      ($urandom_range(0, 9) < 7) ? 32'($urandom) : pick_word());
      end
      req_valid <= 1'b0;

      // drain, then allow for the longest scan
      while (shadow.awaited_results.size() != 0) @(posedge clock);
      repeat (2 * DEPTH_DEFAULT + 8) @(posedge clock);

      if (shadow.awaited_results.size() != 0) begin
         $error("%0d expected results never arrived", shadow.awaited_results.size());
         shadow.failures++;
      end

      $display("covered push %0d, pop %0d, peek %0d, fetch %0d, update %0d, clear %0d,",
               shadow.op_seen[OP_PUSH], shadow.op_seen[OP_POP], shadow.op_seen[OP_PEEK],
               shadow.op_seen[OP_FETCH], shadow.op_seen[OP_UPDATE],
               shadow.op_seen[OP_CLEAR]);
      $display("insert bottom %0d, delete bottom %0d; %0d on a full stack, %0d on empty",
               shadow.op_seen[OP_INS_BOTTOM], shadow.op_seen[OP_DEL_BOTTOM],
               shadow.full_hits, shadow.empty_hits);
      if (shadow.failures == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
